### rtl/cseq_pkg.sv
`timescale 1ns / 1ps
// Package for the ordered byte-key store: sizes, request and status codes.
// Used by char_sequence_insert_delete_store_top, cseq_store_checker and tb; depends on nothing.
package cseq_pkg;

	localparam int DEPTH   = 64;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int KEY_W   = 8;
	localparam int POS_W   = 8;
	localparam int FIELD_W = 7;
	localparam int WIDE_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_READ   = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[FIELD_W-1:0];
	endfunction

endpackage

### rtl/char_sequence_insert_delete_store_top.sv
`timescale 1ns / 1ps
// Top level of the ordered byte-key store with positional insert and delete by key.
// Depends on cseq_pkg and cseq_ram.
//
// Usage:
// A request transaction is taken at a rising edge where start is high and busy is low.
// The request carries req_type, key and position on separate ports.
// Exactly one result transaction follows each request: done is high for one cycle while
// status, count, removed and read_key hold the result.
// The receiver cannot stall; done is a one-cycle strobe and must be captured.
// Errors, unused request types and an insert into an empty store are answered from the
// idle state. A read passes through the read state, which takes the registered RAM data.
// An insert into a non-empty store passes through the shift state; one placed before a
// stored element first moves each element from the slot upward by one place.
// The shift runs one element per cycle through the single RAM read and write ports.
// A delete compacts the store in the delete state, keeping elements unequal to the key.
// The compaction streams every stored element once through the RAM read port.
// busy is high while a request is in progress. The next request may be given in the
// cycle where done is high.
// Reset clears the element count and the control state. The RAM is not cleared:
// entries beyond the count are never used.
module char_sequence_insert_delete_store_top
	import cseq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [KEY_W-1:0]     key,
	input  logic [POS_W-1:0]     position,
	output logic                 done,
	output logic [1:0]           status,
	output logic [FIELD_W-1:0]   count,
	output logic [FIELD_W-1:0]   removed,
	output logic [KEY_W-1:0]     read_key
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_DELETE,
		S_READ
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     at_q;
	logic [CNT_W-1:0]     wr_q;
	logic [KEY_W-1:0]     key_q;
	logic                 pend_s1;
	logic [ADDR_W-1:0]    waddr_s1;

	logic                 done_q;
	status_t              res_status_q;
	logic [FIELD_W-1:0]   res_count_q;
	logic [FIELD_W-1:0]   res_removed_q;
	logic [KEY_W-1:0]     res_key_q;

	logic                 accept;
	logic [WIDE_W-1:0]    pos_wide;
	logic [WIDE_W-1:0]    cnt_wide;
	logic [WIDE_W-1:0]    pos_m1;
	logic [CNT_W-1:0]     idx_m1;
	logic [CNT_W-1:0]     diff;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [KEY_W-1:0]     ram_wdata;
	logic [ADDR_W-1:0]    ram_raddr;
	logic [KEY_W-1:0]     ram_rdata;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign pos_wide = WIDE_W'(position);
	assign cnt_wide = WIDE_W'(count_q);
	assign pos_m1   = pos_wide - WIDE_W'(1);
	assign idx_m1   = idx_q - CNT_W'(1);
	assign diff     = count_q - wr_q;

	cseq_ram #(
		.WIDTH(KEY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = key_q;
		ram_raddr = pos_m1[ADDR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept && req_type == REQ_INSERT && count_q == '0) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = key;
				end
			end
			S_SHIFT: begin
				ram_raddr = idx_m1[ADDR_W-1:0];
				if (pend_s1) begin
					ram_we    = 1'b1;
					ram_waddr = waddr_s1;
					ram_wdata = ram_rdata;
				end else if (idx_q == at_q) begin
					ram_we    = 1'b1;
					ram_waddr = at_q[ADDR_W-1:0];
					ram_wdata = key_q;
				end
			end
			S_DELETE: begin
				ram_raddr = idx_q[ADDR_W-1:0];
				if (pend_s1 && ram_rdata != key_q) begin
					ram_we    = 1'b1;
					ram_waddr = wr_q[ADDR_W-1:0];
					ram_wdata = ram_rdata;
				end
			end
			S_READ: begin
				ram_raddr = pos_m1[ADDR_W-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			at_q          <= '0;
			wr_q          <= '0;
			key_q         <= '0;
			pend_s1       <= 1'b0;
			waddr_s1      <= '0;
			done_q        <= 1'b0;
			res_status_q  <= STAT_OK;
			res_count_q   <= '0;
			res_removed_q <= '0;
			res_key_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q         <= key;
						pend_s1       <= 1'b0;
						res_status_q  <= STAT_OK;
						res_count_q   <= to_field(count_q);
						res_removed_q <= '0;
						res_key_q     <= '0;
						case (req_t'(req_type))
							REQ_INSERT: begin
								if (count_q == '0) begin
									count_q     <= CNT_W'(1);
									res_count_q <= to_field(CNT_W'(1));
									done_q      <= 1'b1;
								end else if (count_q >= CNT_W'(DEPTH)) begin
									res_status_q <= STAT_FULL;
									done_q       <= 1'b1;
								end else if (pos_wide > cnt_wide) begin
									res_status_q <= STAT_RANGE;
									done_q       <= 1'b1;
								end else begin
									idx_q   <= count_q;
									at_q    <= (position == '0) ? count_q : pos_m1[CNT_W-1:0];
									state_q <= S_SHIFT;
								end
							end
							REQ_DELETE: begin
								if (count_q == '0) begin
									res_status_q <= STAT_EMPTY;
									done_q       <= 1'b1;
								end else begin
									idx_q   <= '0;
									wr_q    <= '0;
									state_q <= S_DELETE;
								end
							end
							REQ_READ: begin
								if (count_q == '0) begin
									res_status_q <= STAT_EMPTY;
									done_q       <= 1'b1;
								end else if (position == '0 || pos_wide > cnt_wide) begin
									res_status_q <= STAT_RANGE;
									done_q       <= 1'b1;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SHIFT: begin
					pend_s1 <= (idx_q != at_q);
					if (idx_q != at_q) begin
						idx_q    <= idx_m1;
						waddr_s1 <= idx_q[ADDR_W-1:0];
					end
					if (idx_q == at_q && !pend_s1) begin
						count_q      <= count_q + CNT_W'(1);
						res_count_q  <= to_field(count_q + CNT_W'(1));
						res_status_q <= STAT_OK;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_DELETE: begin
					pend_s1 <= (idx_q != count_q);
					if (idx_q != count_q) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (pend_s1 && ram_rdata != key_q) begin
						wr_q <= wr_q + CNT_W'(1);
					end
					if (idx_q == count_q && !pend_s1) begin
						count_q       <= wr_q;
						res_count_q   <= to_field(wr_q);
						res_removed_q <= to_field(diff);
						res_status_q  <= STAT_OK;
						done_q        <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				S_READ: begin
					res_key_q    <= ram_rdata;
					res_status_q <= STAT_OK;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done     = done_q;
	assign status   = res_status_q;
	assign count    = res_count_q;
	assign removed  = res_removed_q;
	assign read_key = res_key_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while a request is still in progress");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count exceeds the store depth");

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (idx_q >= at_q && count_q < CNT_W'(DEPTH)))
		else $error("insert shift pointer passed the insert slot");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DELETE) |-> (wr_q <= idx_q && idx_q <= count_q))
		else $error("delete write pointer ran ahead of the read pointer");

endmodule

### rtl/cseq_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
module cseq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### tb/cseq_store_checker.sv
`timescale 1ns / 1ps
// Checker for the ordered byte-key store: predicts every request and compares each result.
// Depends on cseq_pkg; instantiated by tb beside char_sequence_insert_delete_store_top.
module cseq_store_checker
	import cseq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         req_type,
	input  logic [KEY_W-1:0]   key,
	input  logic [POS_W-1:0]   position,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [FIELD_W-1:0] count,
	input  logic [FIELD_W-1:0] removed,
	input  logic [KEY_W-1:0]   read_key,
	output int                 mismatch_count,
	output int                 results_due,
	output int                 stored_count,
	output logic [KEY_W-1:0]   head_key
);

	typedef struct packed {
		status_t            st;
		logic [FIELD_W-1:0] cnt;
		logic [FIELD_W-1:0] gone;
		logic [KEY_W-1:0]   rkey;
	} outcome_t;

	logic [KEY_W-1:0] stored_keys [DEPTH];
	int               kept_n;
	outcome_t         due_outcomes [$];

	function automatic outcome_t store_request(input req_t rq, input logic [KEY_W-1:0] k,
		input logic [POS_W-1:0] p);
		outcome_t o;
		int       slot;
		int       w;
		o = '{st: STAT_OK, cnt: '0, gone: '0, rkey: '0};
		case (rq)
			REQ_INSERT: begin
				if (kept_n == 0) begin
					stored_keys[0] = k;
					kept_n = 1;
				end else if (kept_n >= DEPTH) begin
					o.st = STAT_FULL;
				end else if (int'(p) > kept_n) begin
					o.st = STAT_RANGE;
				end else begin
					slot = (p == 0) ? kept_n : int'(p) - 1;
					for (int i = kept_n; i > slot; i--)
						stored_keys[i] = stored_keys[i-1];
					stored_keys[slot] = k;
					kept_n++;
				end
			end
			REQ_DELETE: begin
				if (kept_n == 0) begin
					o.st = STAT_EMPTY;
				end else begin
					w = 0;
					for (int r = 0; r < kept_n; r++) begin
						if (stored_keys[r] != k) begin
							stored_keys[w] = stored_keys[r];
							w++;
						end
					end
					o.gone = FIELD_W'(kept_n - w);
					kept_n = w;
				end
			end
			REQ_READ: begin
				if (kept_n == 0)
					o.st = STAT_EMPTY;
				else if (p == 0 || int'(p) > kept_n)
					o.st = STAT_RANGE;
				else
					o.rkey = stored_keys[int'(p) - 1];
			end
			default: ;
		endcase
		o.cnt = FIELD_W'(kept_n);
		return o;
	endfunction

	function automatic void check_field(input string what, input logic [7:0] exp_v,
		input logic [7:0] got);
		if (got !== exp_v) begin
			mismatch_count++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, got);
		end
	endfunction

	always @(posedge clk) begin
		outcome_t exp_o;
		if (!arst_n) begin
			kept_n = 0;
			due_outcomes.delete();
		end else begin
			if (done === 1'b1) begin
				if (due_outcomes.size() == 0) begin
					mismatch_count++;
					$display("%0t: result transaction with no request outstanding", $time);
				end else begin
					exp_o = due_outcomes.pop_front();
					check_field("status", 8'(exp_o.st), 8'(status));
					check_field("count", 8'(exp_o.cnt), 8'(count));
					check_field("removed", 8'(exp_o.gone), 8'(removed));
					check_field("read_key", exp_o.rkey, read_key);
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				due_outcomes.push_back(store_request(req_t'(req_type), key, position));
		end
		results_due  <= due_outcomes.size();
		stored_count <= kept_n;
		head_key     <= stored_keys[0];
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the ordered byte-key store: clock, reset, requests and verdict.
// Depends on cseq_pkg, char_sequence_insert_delete_store_top and cseq_store_checker.
module tb;
	import cseq_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         req_type;
	logic [KEY_W-1:0]   key;
	logic [POS_W-1:0]   position;
	logic               done;
	logic [1:0]         status;
	logic [FIELD_W-1:0] count;
	logic [FIELD_W-1:0] removed;
	logic [KEY_W-1:0]   read_key;
	int                 mismatch_count;
	int                 results_due;
	int                 stored_count;
	logic [KEY_W-1:0]   head_key;
	int                 issued;

	localparam logic [KEY_W-1:0] KEY_SET [8] = '{8'h00, 8'hFF, 8'h5A, 8'hA5,
		8'h0F, 8'hF0, 8'h33, 8'hCC};

	char_sequence_insert_delete_store_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .key(key), .position(position),
		.done(done), .status(status), .count(count), .removed(removed), .read_key(read_key)
	);

	cseq_store_checker u_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .key(key), .position(position),
		.done(done), .status(status), .count(count), .removed(removed), .read_key(read_key),
		.mismatch_count(mismatch_count), .results_due(results_due),
		.stored_count(stored_count), .head_key(head_key)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 9) < 8)
			return KEY_SET[$urandom_range(0, 7)];
		return KEY_W'($urandom);
	endfunction

	function automatic logic [POS_W-1:0] near_pos(input int n);
		if ($urandom_range(0, 9) == 0)
			return POS_W'($urandom);
		return POS_W'($urandom_range(0, n + 1));
	endfunction

	task automatic issue(input req_t rq, input logic [KEY_W-1:0] k, input logic [POS_W-1:0] p);
		int gap;
		start    <= 1'b1;
		req_type <= rq;
		key      <= k;
		position <= p;
		do @(posedge clk); while (busy !== 1'b0);
		issued++;
		if ((issued < 700 || issued >= 1000) && $urandom_range(0, 99) < 25) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 70) : $urandom_range(1, 4);
			start    <= 1'b0;
			req_type <= 2'($urandom);
			key      <= KEY_W'($urandom);
			position <= POS_W'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		logic [KEY_W-1:0] k;
		issued = 0;
		arst_n   <= 1'b0;
		start    <= 1'b0;
		req_type <= REQ_NONE;
		key      <= '0;
		position <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(REQ_READ,   8'h00, 8'd1);
		issue(REQ_DELETE, 8'h5A, 8'd0);
		issue(REQ_INSERT, 8'h81, 8'd200);
		issue(REQ_INSERT, 8'h11, 8'd3);
		issue(REQ_INSERT, 8'hFF, 8'd0);
		issue(REQ_INSERT, 8'h00, 8'd1);
		issue(REQ_INSERT, 8'h81, 8'd2);
		issue(REQ_INSERT, 8'h7E, 8'd4);
		issue(REQ_INSERT, 8'h22, 8'd6);
		issue(REQ_READ,   8'hFF, 8'd0);
		issue(REQ_READ,   8'h00, 8'd255);
		issue(REQ_READ,   8'h00, 8'd1);
		issue(REQ_READ,   8'h00, 8'd5);
		issue(REQ_DELETE, 8'h33, 8'd0);
		issue(REQ_DELETE, 8'h81, 8'd0);
		issue(REQ_NONE,   8'hFF, 8'hFF);
		issue(REQ_DELETE, 8'h00, 8'd0);
		issue(REQ_DELETE, 8'hFF, 8'd0);
		issue(REQ_DELETE, 8'h7E, 8'd0);
		issue(REQ_READ,   8'h00, 8'd1);
		issue(REQ_INSERT, 8'h42, 8'd0);
		issue(REQ_READ,   8'h00, 8'd2);
		issue(REQ_READ,   8'h00, 8'd1);

		while (issued < 1450) begin
			case ($urandom_range(0, 6))
				0, 1: repeat ($urandom_range(10, 80))
					issue(REQ_INSERT, pick_key(), near_pos(stored_count));
				2: repeat ($urandom_range(5, 30))
					issue(REQ_READ, KEY_W'($urandom), near_pos(stored_count));
				3: repeat ($urandom_range(1, 6))
					issue(REQ_DELETE, pick_key(), POS_W'($urandom));
				4: repeat ($urandom_range(1, 70))
					issue(REQ_DELETE, head_key, POS_W'($urandom));
				5: begin
					k = pick_key();
					repeat ($urandom_range(1, 40))
						issue(REQ_INSERT, k, near_pos(stored_count));
					issue(REQ_DELETE, k, POS_W'($urandom));
				end
				default: repeat ($urandom_range(5, 20))
					issue(req_t'($urandom_range(0, 3)), KEY_W'($urandom), POS_W'($urandom));
			endcase
		end
		start <= 1'b0;

		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/cseq_pkg.sv
rtl/cseq_ram.sv
rtl/char_sequence_insert_delete_store_top.sv
tb/cseq_store_checker.sv
tb/tb.sv
